>>> rtl/qrm_pkg.sv
// qrm_pkg: shared constants, codes and command/status types of the qubit register
// depends on nothing; imported by qrm_datapath, qrm_ctrl, the top level and qrm_checker

package qrm_pkg;

  localparam int unsigned MAX_QUBITS_DEF = 10;

  localparam int unsigned AMP_W     = 16;
  localparam int unsigned ENTRY_W   = 2 * AMP_W;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned DRAW_W    = 16;
  localparam int unsigned SEL_W     = 4;
  localparam int unsigned UQ_W      = 4;
  localparam int unsigned TOL_W     = 28;
  localparam int unsigned SQ_W      = 2 * AMP_W - 1;
  localparam int unsigned MAG_W     = 2 * AMP_W;
  localparam int unsigned RUN_W     = 34;
  localparam int unsigned DRAW_SHIFT = 12;
  localparam int unsigned NORM_ONE  = 1 << 28;

  localparam logic signed [AMP_W-1:0] ONE_Q14 = 16'sd16384;

  localparam logic [SEL_W-1:0] WHOLE_IDX_CODE = 4'd10;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_MEASURE = 1'b1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_USED_QUBITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_TOL    = 1'd1;

  localparam logic [UQ_W-1:0]  USED_QUBITS_RST = 4'd10;
  localparam logic [TOL_W-1:0] NORM_TOL_RST    = 28'd2684;

  typedef struct packed {
    logic rd_en;
    logic search;
    logic acc_clr;
    logic load;
    logic dev_load;
    logic item_wr;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic             pipe_busy;
    logic             found;
    logic             norm_ok;
    logic [IDX_W-1:0] outcome;
  } sts_t;

endpackage

>>> rtl/qrm_ram.sv
// qrm_ram: generic simple dual-port RAM, one write port and one registered read port
// no dependencies

module qrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/qrm_datapath.sv
// qrm_datapath: amplitude store, squared-magnitude pipeline, norm accumulator and draw search
// depends on qrm_pkg and qrm_ram; driven by commands from qrm_ctrl

module qrm_datapath import qrm_pkg::*; #(
  parameter int unsigned MAX_QUBITS = MAX_QUBITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  capture_i,
  input  logic [IDX_W-1:0]      index_i,
  input  logic signed [AMP_W-1:0] amp_real_i,
  input  logic signed [AMP_W-1:0] amp_imag_i,
  input  logic [DRAW_W-1:0]     random_draw_i,
  input  logic [SEL_W-1:0]      bit_select_i,
  input  logic [TOL_W-1:0]      norm_tol_i,
  input  cmd_t                  cmd_i,
  input  logic [MAX_QUBITS-1:0] addr_i,
  output sts_t                  sts_o
);

  localparam int unsigned DEPTH = 1 << MAX_QUBITS;
  localparam int unsigned SUM_W = MAG_W + MAX_QUBITS;

  // latched item fields
  logic [IDX_W-1:0]        index_q;
  logic signed [AMP_W-1:0] re_q;
  logic signed [AMP_W-1:0] im_q;
  logic [DRAW_W-1:0]       draw_q;
  logic [SEL_W-1:0]        sel_q;

  // store ports
  logic                  we;
  logic [MAX_QUBITS-1:0] waddr;
  logic [ENTRY_W-1:0]    wdata;
  logic [ENTRY_W-1:0]    rdata;

  // pipeline
  logic                  v1_q, v2_q, v3_q;
  logic                  m1_q, m2_q, m3_q;
  logic [MAX_QUBITS-1:0] i1_q, i2_q, i3_q;
  logic signed [AMP_W-1:0]   rd_re, rd_im;
  logic signed [2*AMP_W-1:0] sq_re, sq_im;
  logic [SQ_W-1:0]       pr_q, pi_q;
  logic [MAG_W-1:0]      mag_q;

  // accumulate and search
  logic [SUM_W-1:0]        acc_q;
  logic signed [SUM_W:0]   diff;
  logic [SUM_W-1:0]        dev_d, dev_q;
  logic signed [RUN_W-1:0] run_q, run_next;
  logic                    run_le0;
  logic                    found_q;
  logic [MAX_QUBITS-1:0]   win_q;
  logic [MAX_QUBITS-1:0]   win_shift;
  logic [IDX_W-1:0]        outcome;

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      index_q <= index_i;
      re_q    <= amp_real_i;
      im_q    <= amp_imag_i;
      draw_q  <= random_draw_i;
      sel_q   <= bit_select_i;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = MAX_QUBITS'(index_q);
    wdata = {re_q, im_q};
    if (cmd_i.item_wr) begin
      we = 1'b1;
    end else if (cmd_i.clr_wr) begin
      we    = 1'b1;
      waddr = addr_i;
      wdata = (addr_i == win_q) ? {ONE_Q14, {AMP_W{1'b0}}} : '0;
    end
  end

  qrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  assign rd_re = $signed(rdata[ENTRY_W-1:AMP_W]);
  assign rd_im = $signed(rdata[AMP_W-1:0]);
  assign sq_re = rd_re * rd_re;
  assign sq_im = rd_im * rd_im;

  assign run_next = run_q - $signed(RUN_W'(mag_q));
  assign run_le0  = run_next[RUN_W-1] || (run_next == '0);

  assign diff  = $signed({1'b0, acc_q}) - $signed((SUM_W+1)'(NORM_ONE));
  assign dev_d = diff[SUM_W] ? SUM_W'(-diff) : SUM_W'(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (v3_q && m3_q && !found_q && run_le0) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q  <= cmd_i.search;
    m2_q  <= m1_q;
    m3_q  <= m2_q;
    i1_q  <= addr_i;
    i2_q  <= i1_q;
    i3_q  <= i2_q;
    pr_q  <= sq_re[SQ_W-1:0];
    pi_q  <= sq_im[SQ_W-1:0];
    mag_q <= MAG_W'(pr_q) + MAG_W'(pi_q);
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v3_q && !m3_q) begin
      acc_q <= acc_q + SUM_W'(mag_q);
    end
    if (cmd_i.dev_load) begin
      dev_q <= dev_d;
    end
    if (cmd_i.load) begin
      run_q <= $signed(RUN_W'({draw_q, {DRAW_SHIFT{1'b0}}}));
    end else if (v3_q && m3_q && !found_q) begin
      run_q <= run_next;
      if (run_le0) begin
        win_q <= i3_q;
      end
    end
  end

  assign win_shift = win_q >> sel_q;

  always_comb begin
    if (sel_q >= WHOLE_IDX_CODE) begin
      outcome = IDX_W'(win_q);
    end else begin
      outcome = IDX_W'(win_shift[0]);
    end
  end

  assign sts_o.pipe_busy = v1_q | v2_q | v3_q;
  assign sts_o.found     = found_q;
  assign sts_o.norm_ok   = dev_q < SUM_W'(norm_tol_i);
  assign sts_o.outcome   = outcome;

endmodule

>>> rtl/qrm_ctrl.sv
// qrm_ctrl: sequencer for write, norm pass, search pass, result and clearing sweep
// depends on qrm_pkg; commands qrm_datapath and owns the result register

module qrm_ctrl import qrm_pkg::*; #(
  parameter int unsigned MAX_QUBITS = MAX_QUBITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  kind_i,
  output logic                  in_ready_o,
  input  logic [UQ_W-1:0]       used_qubits_i,
  input  sts_t                  sts_i,
  output cmd_t                  cmd_o,
  output logic [MAX_QUBITS-1:0] addr_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  success_o,
  output logic [IDX_W-1:0]      outcome_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SUM_WAIT,
    ST_DEV,
    ST_CHECK,
    ST_SEARCH,
    ST_SEARCH_WAIT,
    ST_RESULT,
    ST_CLEAR
  } state_e;

  state_e                state_q;
  cmd_t                  cmd_q;
  logic [MAX_QUBITS-1:0] addr_q;
  logic                  out_valid_q;
  logic                  success_q;
  logic [IDX_W-1:0]      outcome_q;
  logic [UQ_W-1:0]       qeff;
  logic [MAX_QUBITS-1:0] last_idx;
  logic                  slot_free;

  always_comb begin
    if (used_qubits_i == '0) begin
      qeff = UQ_W'(1);
    end else if (used_qubits_i > MAX_QUBITS) begin
      qeff = UQ_W'(MAX_QUBITS);
    end else begin
      qeff = used_qubits_i;
    end
    for (int b = 0; b < MAX_QUBITS; b++) begin
      last_idx[b] = (b < int'(qeff));
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      success_q   <= 1'b0;
      outcome_q   <= '0;
    end else begin
      if (state_q == ST_RESULT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          cmd_q.item_wr <= in_valid_i && (kind_i == KIND_WRITE);
          cmd_q.acc_clr <= in_valid_i && (kind_i == KIND_MEASURE);
          cmd_q.load    <= in_valid_i && (kind_i == KIND_MEASURE);
          if (in_valid_i && (kind_i == KIND_MEASURE)) begin
            state_q      <= ST_SUM;
            addr_q       <= '0;
            cmd_q.rd_en  <= 1'b1;
            cmd_q.search <= 1'b0;
          end
        end
        ST_SUM: begin
          cmd_q.acc_clr <= 1'b0;
          cmd_q.load    <= 1'b0;
          if (addr_q == last_idx) begin
            cmd_q.rd_en <= 1'b0;
            state_q     <= ST_SUM_WAIT;
          end else begin
            addr_q <= addr_q + MAX_QUBITS'(1);
          end
        end
        ST_SUM_WAIT: begin
          cmd_q.dev_load <= !sts_i.pipe_busy;
          if (!sts_i.pipe_busy) begin
            state_q <= ST_DEV;
          end
        end
        ST_DEV: begin
          cmd_q.dev_load <= 1'b0;
          state_q        <= ST_CHECK;
        end
        ST_CHECK: begin
          if (sts_i.norm_ok) begin
            state_q      <= ST_SEARCH;
            addr_q       <= '0;
            cmd_q.rd_en  <= 1'b1;
            cmd_q.search <= 1'b1;
          end else begin
            state_q <= ST_RESULT;
          end
        end
        ST_SEARCH: begin
          if (addr_q == last_idx) begin
            cmd_q.rd_en <= 1'b0;
            state_q     <= ST_SEARCH_WAIT;
          end else begin
            addr_q <= addr_q + MAX_QUBITS'(1);
          end
        end
        ST_SEARCH_WAIT: begin
          if (!sts_i.pipe_busy) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (slot_free) begin
            success_q   <= sts_i.found;
            outcome_q   <= sts_i.found ? sts_i.outcome : '0;
            if (sts_i.found) begin
              state_q      <= ST_CLEAR;
              addr_q       <= '0;
              cmd_q.clr_wr <= 1'b1;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_CLEAR: begin
          if (addr_q == '1) begin
            cmd_q.clr_wr <= 1'b0;
            state_q      <= ST_IDLE;
          end else begin
            addr_q <= addr_q + MAX_QUBITS'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
          cmd_q   <= '0;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cmd_o       = cmd_q;
  assign addr_o      = addr_q;
  assign out_valid_o = out_valid_q;
  assign success_o   = success_q;
  assign outcome_o   = outcome_q;

endmodule

>>> rtl/qubit_register_measure.sv
// qubit_register_measure: top level, configuration registers, sequencer and datapath
// depends on qrm_pkg, qrm_ctrl and qrm_datapath

// A write item stores one Q2.14 complex amplitude. A measure item walks the
// active store through one read port: a norm pass of 2^used_qubits reads (a
// used_qubits of zero counts as one, one above MAX_QUBITS as MAX_QUBITS), a
// pipeline drain and the norm check, then, only if the check passes, a
// cumulative search pass of as many reads and another drain, then the result.
// A successful measure then sweeps all 2^MAX_QUBITS entries, one per cycle, to
// collapse the state; the result is offered at the start of that sweep, but no
// new item is taken until it ends. The result state holds while the previous
// result still waits. The result register lets the block finish one item while
// the previous result waits. Configuration writes are taken at any time, one
// per cycle.

module qubit_register_measure import qrm_pkg::*; #(
  parameter int unsigned MAX_QUBITS = MAX_QUBITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic [IDX_W-1:0]        index_i,
  input  logic signed [AMP_W-1:0] amp_real_i,
  input  logic signed [AMP_W-1:0] amp_imag_i,
  input  logic [DRAW_W-1:0]       random_draw_i,
  input  logic [SEL_W-1:0]        bit_select_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    success_o,
  output logic [IDX_W-1:0]        outcome_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  logic [UQ_W-1:0]       used_qubits_q;
  logic [TOL_W-1:0]      norm_tol_q;
  logic                  in_accept;
  cmd_t                  cmd;
  sts_t                  sts;
  logic [MAX_QUBITS-1:0] addr;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_qubits_q <= USED_QUBITS_RST;
      norm_tol_q    <= NORM_TOL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_USED_QUBITS: used_qubits_q <= cfg_data_i[UQ_W-1:0];
        CFG_NORM_TOL:    norm_tol_q    <= cfg_data_i[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  qrm_ctrl #(
    .MAX_QUBITS (MAX_QUBITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .kind_i        (kind_i),
    .in_ready_o    (in_ready_o),
    .used_qubits_i (used_qubits_q),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .addr_o        (addr),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .success_o     (success_o),
    .outcome_o     (outcome_o)
  );

  qrm_datapath #(
    .MAX_QUBITS (MAX_QUBITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .capture_i     (in_accept),
    .index_i       (index_i),
    .amp_real_i    (amp_real_i),
    .amp_imag_i    (amp_imag_i),
    .random_draw_i (random_draw_i),
    .bit_select_i  (bit_select_i),
    .norm_tol_i    (norm_tol_q),
    .cmd_i         (cmd),
    .addr_i        (addr),
    .sts_o         (sts)
  );

endmodule

>>> rtl/qrm_checker.sv
// qrm_checker: port-level assertions for the qubit register, bound to the top level
// depends on qrm_pkg

module qrm_checker import qrm_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  kind_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  success_o,
  input logic [IDX_W-1:0]      outcome_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(success_o) && $stable(outcome_o))
    else $error("result changed while stalled");

  // failed measure reports zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !success_o |-> outcome_o == '0)
    else $error("failed measure with nonzero outcome");

  // a measure item blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_MEASURE |=> !in_ready_o)
    else $error("item taken right after a measure");

  // a new result only appears out of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without a measure in flight");

  // configuration port never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind qubit_register_measure qrm_checker u_qrm_checker (.*);
